### sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/slfe_pkg.sv
`default_nettype none

package slfe_pkg;

    // Request codes
    localparam logic [1:0] REQ_CMD  = 2'd0;
    localparam logic [1:0] REQ_NIB  = 2'd1;
    localparam logic [1:0] REQ_SHOW = 2'd2;
    localparam logic [1:0] REQ_INIT = 2'd3;

    localparam logic [3:0] CMD_LEN  = 4'd12;
    localparam logic [3:0] DATA_LEN = 4'd13;

    localparam logic [12:0] CMD_MARK  = 13'h0800;
    localparam logic [12:0] DATA_MARK = 13'h1400;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  cmd_byte;
        logic [5:0]  nibble_addr;
        logic [3:0]  nibble_data;
        logic [13:0] shown_value;
        logic        show_dot;
    } t_req;

    typedef struct packed {
        logic [12:0] frame_word;
        logic [3:0]  frame_length;
        logic        last;
    } t_frame;

    // Classified item as it waits in the queue; pat[0] is the thousands digit.
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       cmd_byte;
        logic [5:0]       nibble_addr;
        logic [3:0]       nibble_data;
        logic [3:0][7:0]  pat;
    } t_job;

endpackage

`default_nettype wire

### sv/slfe_front.sv
`default_nettype none

module slfe_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire slfe_pkg::t_req i_req,
    input  wire logic           i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output slfe_pkg::t_job      o_job
);
    import slfe_pkg::*;

    localparam logic [13:0] VALUE_MAX = 14'd9999;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [7:0]  DOT_BIT   = 8'h10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  cmd_byte;
        logic [5:0]  nibble_addr;
        logic [3:0]  nibble_data;
        logic        dot;
        logic [13:0] value;
        logic [6:0]  hi;
    } t_stage;

    function automatic logic [7:0] seg_pat(input logic [3:0] digit);
        logic [7:0] p;
        unique case (digit)
            4'd0:    p = 8'hEB;
            4'd1:    p = 8'h0A;
            4'd2:    p = 8'hAD;
            4'd3:    p = 8'h8F;
            4'd4:    p = 8'h4E;
            4'd5:    p = 8'hC7;
            4'd6:    p = 8'hE7;
            4'd7:    p = 8'h8A;
            4'd8:    p = 8'hEF;
            4'd9:    p = 8'hCF;
            default: p = 8'hEB;
        endcase
        return p;
    endfunction

    // Split 0..99 into tens and units: (x * 205) >> 11 is x / 10 here.
    function automatic logic [7:0] split_tens(input logic [6:0] x);
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  u;
        p = 15'(x) * 15'd205;
        t = p[14:11];
        u = x - 7'(t) * 7'd10;
        return {t, u[3:0]};
    endfunction

    logic   r_v1, r_v2, r_v3;
    t_stage r_s1, r_s2, r_s3;
    t_stage n_s2, n_s3;
    logic   ld1, ld2, ld3;

    logic [26:0] prod;
    logic [13:0] diff;
    logic [7:0]  hi_dig, lo_dig;

    assign o_push = r_v3 && !i_q_full;
    assign ld3    = !r_v3 || o_push;
    assign ld2    = !r_v2 || ld3;
    assign ld1    = !r_v1 || ld2;
    assign o_ready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_accept;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
        end
    end

    // Stage 2 quotient by 100 through a reciprocal multiply
    assign prod = 27'(r_s1.value) * 27'(RECIP_100);
    // Stage 3 remainder below 100
    assign diff = r_s2.value - 14'(r_s2.hi) * 14'd100;

    always_comb begin
        n_s2       = r_s1;
        n_s2.hi    = prod[25:19];
        n_s3       = r_s2;
        n_s3.value = {7'd0, diff[6:0]};
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1.kind        <= i_req.req_type;
            r_s1.cmd_byte    <= i_req.cmd_byte;
            r_s1.nibble_addr <= i_req.nibble_addr;
            r_s1.nibble_data <= i_req.nibble_data;
            r_s1.dot         <= i_req.show_dot;
            r_s1.value       <= (i_req.shown_value > VALUE_MAX) ? VALUE_MAX
                                                                 : i_req.shown_value;
            r_s1.hi          <= '0;
        end
        if (ld2) r_s2 <= n_s2;
        if (ld3) r_s3 <= n_s3;
    end

    assign hi_dig = split_tens(r_s3.hi);
    assign lo_dig = split_tens(r_s3.value[6:0]);

    always_comb begin
        o_job.kind        = r_s3.kind;
        o_job.cmd_byte    = r_s3.cmd_byte;
        o_job.nibble_addr = r_s3.nibble_addr;
        o_job.nibble_data = r_s3.nibble_data;
        o_job.pat[0]      = seg_pat(hi_dig[7:4]) | (r_s3.dot ? DOT_BIT : 8'h00);
        o_job.pat[1]      = seg_pat(hi_dig[3:0]);
        o_job.pat[2]      = seg_pat(lo_dig[7:4]);
        o_job.pat[3]      = seg_pat(lo_dig[3:0]);
    end

endmodule

`default_nettype wire

### sv/slfe_queue.sv
`default_nettype none

module slfe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire slfe_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output slfe_pkg::t_job      o_job
);
    import slfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            if (do_pop) r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

`default_nettype wire

### sv/slfe_back.sv
`default_nettype none

module slfe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire slfe_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_strobe,
    output slfe_pkg::t_frame    o_frame
);
    import slfe_pkg::*;

    localparam logic [2:0] LAST_ONE  = 3'd0;
    localparam logic [2:0] LAST_INIT = 3'd5;
    localparam logic [2:0] LAST_SHOW = 3'd7;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h52;
            3'd1:    c = 8'h30;
            3'd2:    c = 8'h00;
            3'd3:    c = 8'h0A;
            3'd4:    c = 8'h02;
            3'd5:    c = 8'h06;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    logic [2:0] r_idx;
    logic       r_strobe;
    t_frame     r_frame;
    logic [2:0] last_idx;
    logic [7:0] pat;
    t_frame     frame;

    assign pat = i_job.pat[r_idx[2:1]];

    always_comb begin
        unique case (i_job.kind)
            REQ_CMD: begin
                last_idx           = LAST_ONE;
                frame.frame_word   = CMD_MARK | {5'd0, i_job.cmd_byte};
                frame.frame_length = CMD_LEN;
            end
            REQ_NIB: begin
                last_idx           = LAST_ONE;
                frame.frame_word   = DATA_MARK | {3'd0, i_job.nibble_addr, i_job.nibble_data};
                frame.frame_length = DATA_LEN;
            end
            REQ_INIT: begin
                last_idx           = LAST_INIT;
                frame.frame_word   = CMD_MARK | {5'd0, init_cmd(r_idx)};
                frame.frame_length = CMD_LEN;
            end
            default: begin
                // Show value: high nibble on even addresses, low on odd
                last_idx           = LAST_SHOW;
                frame.frame_word   = DATA_MARK | {3'd0, 3'd0, r_idx,
                                                  (r_idx[0] ? pat[3:0] : pat[7:4])};
                frame.frame_length = DATA_LEN;
            end
        endcase
        frame.last = (r_idx == last_idx);
    end

    assign o_pop = i_valid && frame.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
            if (i_valid) r_idx <= frame.last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) r_frame <= frame;
    end

    assign o_strobe = r_strobe;
    assign o_frame  = r_frame;

endmodule

`default_nettype wire

### sv/segment_lcd_frame_encoder_core.sv
`default_nettype none
// Segment LCD frame encoder.
// Input: raise start with a request on i_req; the item is taken at a clock
// edge where start is high and busy is low. Requests: command byte, nibble
// write, show a decimal value (saturated to 9999) and the init sequence.
// Output: each frame appears on o_frame for one cycle with o_strobe high;
// frame_word is right aligned and sent MSB first over frame_length bits, and
// last marks the final frame of a request. The receiver cannot stall.
// Path: an item passes the three front stages of digit conversion, then the
// queue; the queue head feeds the output register, whose frame shows on the
// strobe.
// Throughput: the back end emits one frame per cycle while the queue holds an
// item; an item gives 1 frame (command, nibble), 6 (init) or 8 (show value).
// The front takes items until its three stages and the QUEUE_DEPTH-entry
// queue fill; busy then stays high until the back end pops an item.
// Reset (synchronous, active low) empties the pipeline and the queue and
// drops any frame in progress.
module segment_lcd_frame_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire slfe_pkg::t_req i_req,
    output logic                busy,
    output logic                o_strobe,
    output slfe_pkg::t_frame    o_frame
);
    import slfe_pkg::*;

    logic accept, ready, push, q_full, q_valid, pop;
    t_job front_job, head_job;

    assign busy   = !ready;
    assign accept = start && ready;

    slfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_ready  (ready),
        .o_push   (push),
        .o_job    (front_job)
    );

    slfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    slfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_frame  (o_frame)
    );

endmodule

`default_nettype wire

### sv/slfe_checker.sv
`default_nettype none
`include "assert_macros.svh"

module slfe_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_strobe,
    input wire slfe_pkg::t_frame o_frame
);
    import slfe_pkg::*;

    `ASSERT_IMPL(a_len_legal, i_clk, i_rst_n, o_strobe, (o_frame.frame_length == CMD_LEN || o_frame.frame_length == DATA_LEN), "frame length is neither command nor data")
    `ASSERT_IMPL(a_cmd_mark, i_clk, i_rst_n, o_strobe && o_frame.frame_length == CMD_LEN, o_frame.frame_word[12:8] == 5'b01000, "command frame lacks its mark")
    `ASSERT_IMPL(a_data_mark, i_clk, i_rst_n, o_strobe && o_frame.frame_length == DATA_LEN, o_frame.frame_word[12:10] == 3'b101, "data frame lacks its mark")
    `ASSERT_CLK(a_busy_cause, i_clk, i_rst_n, $rose(busy) |-> $past(start), "busy rose without an item taken")

endmodule

bind segment_lcd_frame_encoder_core slfe_checker u_slfe_checker (.*);

`default_nettype wire
